### hw/rtl/hill_cipher_decrypt_macros.svh
// Assertion macros for the checker file of the Hill cipher decrypter.
`ifndef HILL_CIPHER_DECRYPT_MACROS_SVH
`define HILL_CIPHER_DECRYPT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define HCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that must also hold while reset is asserted
`define HCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/hcd_pkg.sv
// Types, constants and mod-26 helper functions of the Hill cipher decrypter.
`default_nettype none

package hcd_pkg;

    localparam int MAX_BLOCK = 3;
    localparam int BUF_AW    = $clog2(MAX_BLOCK);
    localparam int ALPHA     = 26;
    localparam int KEY_W     = 45;
    localparam int LETTER_W  = 5;
    localparam int STORE_N   = 9;
    localparam int STORE_AW  = 4;

    localparam logic [6:0] CHAR_A        = 7'd65;
    localparam logic [4:0] NO_INV_FACTOR = 5'd25;
    localparam logic [9:0] SUB_BIAS      = 10'(ALPHA * ALPHA);

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] CFG_KEY_MATRIX = 2'd1;
    localparam logic [1:0] SIZE_3X3       = 2'd3;

    typedef enum logic {
        A_KEY   = 1'b0,
        A_STORE = 1'b1
    } a_sel_t;

    typedef enum logic [1:0] {
        B_KEY    = 2'd0,
        B_FACTOR = 2'd1,
        B_LETTER = 2'd2
    } b_sel_t;

    typedef struct packed {
        logic                go;
        logic                clr;
        logic                sub;
        a_sel_t              a_sel;
        logic [STORE_AW-1:0] a_idx;
        b_sel_t              b_sel;
        logic [STORE_AW-1:0] b_idx;
        logic                wr_store;
        logic [STORE_AW-1:0] wr_idx;
        logic                set_factor;
        logic                put_out;
        logic                out_last;
        logic                buf_wr;
        logic [BUF_AW-1:0]   buf_idx;
    } hcd_ctrl_t;

    // Row-major slot of entry (r, c) in a 3x3 layout
    function automatic logic [STORE_AW-1:0] idx9(input logic [1:0] r, input logic [1:0] c);
        return STORE_AW'(r) * STORE_AW'(3) + STORE_AW'(c);
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic logic [1:0] dec3(input logic [1:0] x);
        return (x == 2'd0) ? 2'd2 : x - 2'd1;
    endfunction

    // Fold a 5-bit code into 0..25
    function automatic logic [4:0] red26(input logic [4:0] v);
        return (v >= 5'(ALPHA)) ? v - 5'(ALPHA) : v;
    endfunction

    // x mod 26 for x below 1024: 32 is 6 mod 26, so fold the upper bits twice
    function automatic logic [4:0] mod26(input logic [9:0] x);
        logic [7:0] y;
        logic [6:0] z;
        y = 8'(x[9:5]) * 8'd6 + 8'(x[4:0]);
        z = 7'(y[7:5]) * 7'd6 + 7'(y[4:0]);
        if (z >= 7'(2 * ALPHA)) begin
            return 5'(z - 7'(2 * ALPHA));
        end
        else if (z >= 7'(ALPHA)) begin
            return 5'(z - 7'(ALPHA));
        end
        return 5'(z);
    endfunction

    // Multiplicative inverse mod 26, zero where none exists
    function automatic logic [4:0] unit_inv(input logic [4:0] d);
        logic [4:0] r;
        unique case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hcd_mac.sv
// Shared two-stage multiply-accumulate unit modulo 26.
`default_nettype none

module hcd_mac import hcd_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic                clr,
    input  wire logic                sub,
    input  wire logic [LETTER_W-1:0] a,
    input  wire logic [LETTER_W-1:0] b,
    output logic      [LETTER_W-1:0] acc
);

    logic                vld_reg;
    logic                clr_reg;
    logic                sub_reg;
    logic [9:0]          prod_reg;
    logic [LETTER_W-1:0] acc_reg;
    logic [LETTER_W-1:0] base;
    logic [9:0]          sum;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= go;
        end
    end

    always_ff @(posedge clk) begin
        if (go) begin
            prod_reg <= 10'(a) * 10'(b);
            clr_reg  <= clr;
            sub_reg  <= sub;
        end
        if (vld_reg) begin
            acc_reg <= mod26(sum);
        end
    end

    // Bias the subtraction by 26*26 so the sum never goes negative
    assign base = clr_reg ? '0 : acc_reg;
    assign sum  = sub_reg ? 10'(base) + SUB_BIAS - prod_reg : 10'(base) + prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

### hw/rtl/hcd_seq.sv
// Sequencer: letter fill tracking, key inversion and decryption micro-steps.
`default_nettype none

module hcd_seq import hcd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      cfg_write,
    input  wire logic      n3,
    input  wire logic      out_free,
    output logic           in_ready,
    output hcd_ctrl_t      ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WB    = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        PH_COF   = 4'b0001,
        PH_DET   = 4'b0010,
        PH_SCALE = 4'b0100,
        PH_DEC   = 4'b1000
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] op_reg, op_next;
    logic [1:0] fill_reg, fill_next;
    logic       inv_ready_reg, inv_ready_next;
    logic       blk_full_reg, blk_full_next;

    logic       accept;
    logic       op_last;
    logic [1:0] nm1;
    logic [1:0] r1, r2, c1, c2;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign nm1      = n3 ? 2'd2 : 2'd1;
    assign r1       = inc3(row_reg);
    assign r2       = dec3(row_reg);
    assign c1       = inc3(col_reg);
    assign c2       = dec3(col_reg);

    // Micro-step decode
    always_comb begin
        ctrl         = '0;
        ctrl.a_sel   = A_KEY;
        ctrl.b_sel   = B_KEY;
        ctrl.buf_wr  = accept;
        ctrl.buf_idx = fill_reg[BUF_AW-1:0];
        op_last      = 1'b0;
        if (state_reg == ST_ISSUE) begin
            ctrl.go = 1'b1;
            unique case (phase_reg)
                PH_COF: begin
                    // cofactor: K(r1,c1)*K(r2,c2) - K(r1,c2)*K(r2,c1)
                    op_last = (op_reg == 2'd1);
                    if (op_reg == 2'd0) begin
                        ctrl.clr   = 1'b1;
                        ctrl.a_idx = idx9(r1, c1);
                        ctrl.b_idx = idx9(r2, c2);
                    end
                    else begin
                        ctrl.sub   = 1'b1;
                        ctrl.a_idx = idx9(r1, c2);
                        ctrl.b_idx = idx9(r2, c1);
                    end
                end
                PH_DET: begin
                    op_last  = (op_reg == nm1);
                    ctrl.clr = (op_reg == 2'd0);
                    if (n3) begin
                        ctrl.a_sel = A_STORE;
                        ctrl.a_idx = idx9(2'd0, op_reg);
                        ctrl.b_idx = idx9(2'd0, op_reg);
                    end
                    else if (op_reg == 2'd0) begin
                        ctrl.a_idx = idx9(2'd0, 2'd0);
                        ctrl.b_idx = idx9(2'd1, 2'd1);
                    end
                    else begin
                        ctrl.sub   = 1'b1;
                        ctrl.a_idx = idx9(2'd0, 2'd1);
                        ctrl.b_idx = idx9(2'd1, 2'd0);
                    end
                end
                PH_SCALE: begin
                    op_last    = 1'b1;
                    ctrl.clr   = 1'b1;
                    ctrl.b_sel = B_FACTOR;
                    if (n3) begin
                        ctrl.a_sel = A_STORE;
                        ctrl.a_idx = idx9(row_reg, col_reg);
                    end
                    else begin
                        // 2x2 adjugate: swap the diagonal, negate the off-diagonal
                        ctrl.sub   = (row_reg != col_reg);
                        ctrl.a_idx = idx9({1'b0, ~col_reg[0]}, {1'b0, ~row_reg[0]});
                    end
                end
                PH_DEC: begin
                    op_last    = (op_reg == nm1);
                    ctrl.clr   = (op_reg == 2'd0);
                    ctrl.a_sel = A_STORE;
                    ctrl.a_idx = idx9(op_reg, row_reg);
                    ctrl.b_sel = B_LETTER;
                    ctrl.b_idx = STORE_AW'(op_reg);
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_WB) begin
            unique case (phase_reg)
                PH_COF: begin
                    ctrl.wr_store = 1'b1;
                    ctrl.wr_idx   = idx9(row_reg, col_reg);
                end
                PH_DET: begin
                    ctrl.set_factor = 1'b1;
                end
                PH_SCALE: begin
                    ctrl.wr_store = 1'b1;
                    ctrl.wr_idx   = n3 ? idx9(row_reg, col_reg) : idx9(col_reg, row_reg);
                end
                PH_DEC: begin
                    ctrl.put_out  = out_free;
                    ctrl.out_last = (row_reg == nm1);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        op_next        = op_reg;
        fill_next      = fill_reg;
        inv_ready_next = inv_ready_reg;
        blk_full_next  = blk_full_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    blk_full_next = (fill_reg == nm1);
                    fill_next     = (fill_reg == nm1) ? 2'd0 : fill_reg + 2'd1;
                    row_next      = 2'd0;
                    col_next      = 2'd0;
                    op_next       = 2'd0;
                    if (!inv_ready_reg) begin
                        phase_next = n3 ? PH_COF : PH_DET;
                        state_next = ST_ISSUE;
                    end
                    else if (fill_reg == nm1) begin
                        phase_next = PH_DEC;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                if (op_last) begin
                    op_next    = 2'd0;
                    state_next = ST_DRAIN;
                end
                else begin
                    op_next = op_reg + 2'd1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                unique case (phase_reg)
                    PH_COF: begin
                        state_next = ST_ISSUE;
                        if (row_reg == 2'd2 && col_reg == 2'd2) begin
                            phase_next = PH_DET;
                            row_next   = 2'd0;
                            col_next   = 2'd0;
                        end
                        else if (col_reg == 2'd2) begin
                            col_next = 2'd0;
                            row_next = row_reg + 2'd1;
                        end
                        else begin
                            col_next = col_reg + 2'd1;
                        end
                    end
                    PH_DET: begin
                        phase_next = PH_SCALE;
                        state_next = ST_ISSUE;
                    end
                    PH_SCALE: begin
                        if (row_reg == nm1 && col_reg == nm1) begin
                            inv_ready_next = 1'b1;
                            row_next       = 2'd0;
                            col_next       = 2'd0;
                            if (blk_full_reg) begin
                                phase_next = PH_DEC;
                                state_next = ST_ISSUE;
                            end
                            else begin
                                state_next = ST_IDLE;
                            end
                        end
                        else begin
                            state_next = ST_ISSUE;
                            if (col_reg == nm1) begin
                                col_next = 2'd0;
                                row_next = row_reg + 2'd1;
                            end
                            else begin
                                col_next = col_reg + 2'd1;
                            end
                        end
                    end
                    PH_DEC: begin
                        // hold the row result until the output register frees up
                        if (out_free) begin
                            if (row_reg == nm1) begin
                                state_next = ST_IDLE;
                            end
                            else begin
                                row_next   = row_reg + 2'd1;
                                state_next = ST_ISSUE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
        // any register write drops the partial block and forces a new inverse
        if (cfg_write) begin
            fill_next      = 2'd0;
            inv_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DEC;
            row_reg       <= 2'd0;
            col_reg       <= 2'd0;
            op_reg        <= 2'd0;
            fill_reg      <= 2'd0;
            inv_ready_reg <= 1'b0;
            blk_full_reg  <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            op_reg        <= op_next;
            fill_reg      <= fill_next;
            inv_ready_reg <= inv_ready_next;
            blk_full_reg  <= blk_full_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hill_cipher_decrypt.sv
// Top level of the Hill cipher decrypter: registers, operand selection, output stage.
`default_nettype none

// Hill cipher decryption mod 26 with a 2x2 or 3x3 key. Ciphertext letters
// (0..25, codes 26..31 fold mod 26) are taken one per transaction and buffered
// until a block is full; then one plaintext character 'A'..'Z' per row comes
// out in order, with last_of_block on the final one. A letter that does not
// finish a block leaves in_ready high. A finishing letter keeps in_ready low
// until its block is out, as the rows go through the single shared two-stage
// multiply-accumulate unit: one operation issued per cycle, then a drain and
// a writeback state per row; a stalled output adds its wait. The first letter
// after reset or any register write also derives the inverse key through the
// same unit, and in_ready stays low until that is done. A key with no inverse
// uses the factor 25 and shows key_invertible low. Any register write discards a
// partial block. Write registers only while no transaction is in progress.
module hill_cipher_decrypt import hcd_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [LETTER_W-1:0] letter_index,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [6:0]          letter_code,
    output logic                     last_of_block,
    output logic                     key_invertible,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [KEY_W-1:0]    cfg_data
);

    hcd_ctrl_t           ctrl;
    logic                n3_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LETTER_W-1:0] buf_reg [MAX_BLOCK];
    logic [LETTER_W-1:0] store_reg [STORE_N];
    logic [LETTER_W-1:0] factor_reg;
    logic                flag_reg;
    logic                out_valid_reg;
    logic [6:0]          out_code_reg;
    logic                out_last_reg;
    logic                out_inv_reg;

    logic                out_free;
    logic [5:0]          a_off;
    logic [5:0]          b_off;
    logic [LETTER_W-1:0] op_a;
    logic [LETTER_W-1:0] op_b;
    logic [LETTER_W-1:0] acc;
    logic [LETTER_W-1:0] inv;

    assign out_free = !out_valid_reg || out_ready;

    hcd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_write (cfg_write),
        .n3        (n3_reg),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .ctrl      (ctrl)
    );

    assign a_off = 6'(ctrl.a_idx) * 6'(LETTER_W);
    assign b_off = 6'(ctrl.b_idx) * 6'(LETTER_W);

    always_comb begin
        unique case (ctrl.a_sel)
            A_KEY:   op_a = red26(key_reg[a_off +: LETTER_W]);
            A_STORE: op_a = store_reg[ctrl.a_idx];
        endcase
    end

    always_comb begin
        unique case (ctrl.b_sel)
            B_KEY:    op_b = red26(key_reg[b_off +: LETTER_W]);
            B_FACTOR: op_b = factor_reg;
            B_LETTER: op_b = buf_reg[ctrl.b_idx[BUF_AW-1:0]];
            default:  op_b = '0;
        endcase
    end

    hcd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (ctrl.go),
        .clr   (ctrl.clr),
        .sub   (ctrl.sub),
        .a     (op_a),
        .b     (op_b),
        .acc   (acc)
    );

    assign inv = unit_inv(acc);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            n3_reg        <= 1'b0;
            key_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == CFG_BLOCK_SIZE) begin
                    n3_reg <= (cfg_data[1:0] == SIZE_3X3) && (MAX_BLOCK >= 3);
                end
                else if (cfg_index == CFG_KEY_MATRIX) begin
                    key_reg <= cfg_data;
                end
            end
            if (ctrl.set_factor) begin
                flag_reg <= (inv != '0);
            end
            if (ctrl.put_out) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.buf_wr) begin
            buf_reg[ctrl.buf_idx] <= red26(letter_index);
        end
        if (ctrl.wr_store) begin
            store_reg[ctrl.wr_idx] <= acc;
        end
        if (ctrl.set_factor) begin
            factor_reg <= (inv != '0) ? inv : NO_INV_FACTOR;
        end
        if (ctrl.put_out) begin
            out_code_reg <= CHAR_A + 7'(acc);
            out_last_reg <= ctrl.out_last;
            out_inv_reg  <= flag_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign letter_code    = out_code_reg;
    assign last_of_block  = out_last_reg;
    assign key_invertible = out_inv_reg;

endmodule

`default_nettype wire

### hw/rtl/hcd_checker.sv
// Port-level checker for the Hill cipher decrypter and its bind to the top level.
`default_nettype none

`include "hill_cipher_decrypt_macros.svh"

module hcd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [6:0] letter_code,
    input wire logic       last_of_block,
    input wire logic       key_invertible
);

    // A stalled result holds its whole payload
    `HCD_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(letter_code)
            && $stable(last_of_block) && $stable(key_invertible),
        "output transaction changed while stalled")

    // Once reset has been seen at an edge, no result is shown
    `HCD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid during reset")

    // Mid-block the sequencer is still busy with the remaining rows
    `HCD_ASSERT(a_block_busy, out_valid && !last_of_block |-> !in_ready,
        "input taken before block was fully emitted")

endmodule

bind hill_cipher_decrypt hcd_checker u_hcd_checker (.*);

`default_nettype wire
